// ----- rtl/core/frustum_segment_metrics_macros.svh -----
// assertion macros for the frustum segment metrics block
`ifndef FRUSTUM_SEGMENT_METRICS_MACROS_SVH
`define FRUSTUM_SEGMENT_METRICS_MACROS_SVH
`ifndef SYNTHESIS
// checked while out of reset
`define FSEGM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked at every edge, reset included
`define FSEGM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FSEGM_ASSERT(lbl, clk, rst_n, prop, msg)
`define FSEGM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/core/fsegm_pkg.sv -----
// types, constants and helper functions of the frustum segment metrics block
package fsegm_pkg;

  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned COORD_W     = 24;
  localparam int unsigned RADIUS_W    = 20;
  localparam int unsigned METRIC_W    = 48;
  localparam int unsigned DIFF_W      = 24;
  localparam int unsigned SQ_W        = 48;
  localparam int unsigned RSQ_W       = 40;
  localparam int unsigned RSUM_W      = 21;
  localparam int unsigned RAD_IN_W    = 50;
  localparam int unsigned SUMSQ_W     = 42;
  localparam int unsigned SQRT_ITERS  = 28;
  localparam int unsigned SQRT_PER_ST = 4;
  localparam int unsigned SQRT_STAGES = SQRT_ITERS / SQRT_PER_ST;
  localparam int unsigned RAD_W       = 2 * SQRT_ITERS;
  localparam int unsigned ROOT_W      = SQRT_ITERS;
  localparam int unsigned REM_W       = SQRT_ITERS + 2;
  localparam int unsigned PI_W        = 18;
  localparam int unsigned PI3_W       = 17;
  localparam int unsigned SP_W        = SUMSQ_W + PI3_W;
  localparam int unsigned SP_LO_W     = 30;
  localparam int unsigned SP_HI_W     = SP_W - SP_LO_W;
  localparam int unsigned P1_W        = RSUM_W + ROOT_W;
  localparam int unsigned P2_W        = P1_W + PI_W;
  localparam int unsigned VLO_W       = ROOT_W + SP_LO_W;
  localparam int unsigned VHI_W       = ROOT_W + SP_HI_W;
  localparam int unsigned V_W         = ROOT_W + SP_W + 1;
  localparam int unsigned SURF_SHIFT  = FRAC_BITS + 16;
  localparam int unsigned VOL_SHIFT   = 2 * FRAC_BITS + 16;

  localparam logic [PI_W-1:0]     PI_Q16       = PI_W'(205887);
  localparam logic [PI3_W-1:0]    PI_THIRD_Q16 = PI3_W'(68629);
  localparam logic [METRIC_W-1:0] METRIC_MAX   = '1;

  typedef enum logic [1:0] {
    OP_SURFACE = 2'd0,
    OP_VOLUME  = 2'd1,
    OP_LENGTH  = 2'd2,
    OP_MEAN    = 2'd3
  } op_e;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    op_e               op;
    logic              missing;
    logic [RSUM_W-1:0] rsum;
    logic [SP_W-1:0]   sp;
  } side_t;

  // one digit of the restoring square root, two radicand bits per digit
  function automatic sqrt_t sqrt_step(sqrt_t s);
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    sqrt_t            r;
    rem2  = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial = {s.root, 2'b01};
    r.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (rem2 >= trial) begin
      r.rem  = rem2 - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = rem2;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [DIFF_W-1:0] abs_diff(logic signed [COORD_W-1:0] a,
                                                 logic signed [COORD_W-1:0] b);
    logic signed [COORD_W:0] d;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    return d[COORD_W] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

endpackage

// ----- rtl/core/fsegm_if.sv -----
// valid/ready channels for segment items and metric results
interface fsegm_in_if;
  logic                                       valid;
  logic                                       ready;
  logic [1:0]                                 operation;
  logic                                       node_missing;
  logic signed [fsegm_pkg::COORD_W-1:0]       start_x;
  logic signed [fsegm_pkg::COORD_W-1:0]       start_y;
  logic signed [fsegm_pkg::COORD_W-1:0]       start_z;
  logic [fsegm_pkg::RADIUS_W-1:0]             start_radius;
  logic signed [fsegm_pkg::COORD_W-1:0]       stop_x;
  logic signed [fsegm_pkg::COORD_W-1:0]       stop_y;
  logic signed [fsegm_pkg::COORD_W-1:0]       stop_z;
  logic [fsegm_pkg::RADIUS_W-1:0]             stop_radius;

  modport source (output valid, operation, node_missing, start_x, start_y, start_z,
                  start_radius, stop_x, stop_y, stop_z, stop_radius, input ready);
  modport sink   (input valid, operation, node_missing, start_x, start_y, start_z,
                  start_radius, stop_x, stop_y, stop_z, stop_radius, output ready);
endinterface

interface fsegm_out_if;
  logic                            valid;
  logic                            ready;
  logic [fsegm_pkg::METRIC_W-1:0]  metric;
  logic                            saturated;

  modport source (output valid, metric, saturated, input ready);
  modport sink   (input valid, metric, saturated, output ready);
endinterface

// ----- rtl/core/frustum_segment_metrics.sv -----
// top level of the frustum segment metrics pipeline
// Frustum segment metrics: one segment in, one metric out. The pipe has 13
// register stages, the input transfer edge loads the first, and a new segment
// is taken every cycle while the result side keeps taking transfers. The depth
// is set by the square root, 28 digits at four digits per stage (7 stages);
// squares, the wide volume product (split in two partial products) and the
// final shift and saturation take the rest. The whole pipe stalls as one when
// a finished result is not taken, so nothing is dropped or repeated.
`include "frustum_segment_metrics_macros.svh"

module frustum_segment_metrics (
  input  logic        clk_i,
  input  logic        rst_ni,
  fsegm_in_if.sink    in_i,
  fsegm_out_if.source out_o
);

  localparam int unsigned NST = 6 + fsegm_pkg::SQRT_STAGES; // valid stages

  // pipe valid bits; index NST-1 is the output register
  logic [NST-1:0] v_q, v_d;
  logic           en;

  // one enable for the whole pipe: move when the output slot is free or drains
  assign en         = out_o.ready || !v_q[NST-1];
  assign in_i.ready = en;
  assign out_o.valid = v_q[NST-1];

  assign v_d = {v_q[NST-2:0], in_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= v_d;
    end
  end

  // stage 0: register differences and radius sums
  fsegm_pkg::op_e                      op0_q;
  logic                                miss0_q;
  logic [fsegm_pkg::DIFF_W-1:0]        dx0_q, dy0_q, dz0_q;
  logic [fsegm_pkg::RADIUS_W-1:0]      dr0_q, r1_0_q, r2_0_q;
  logic [fsegm_pkg::RSUM_W-1:0]        rsum0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      op0_q   <= fsegm_pkg::op_e'(in_i.operation);
      miss0_q <= in_i.node_missing;
      dx0_q   <= fsegm_pkg::abs_diff(in_i.start_x, in_i.stop_x);
      dy0_q   <= fsegm_pkg::abs_diff(in_i.start_y, in_i.stop_y);
      dz0_q   <= fsegm_pkg::abs_diff(in_i.start_z, in_i.stop_z);
      dr0_q   <= (in_i.start_radius >= in_i.stop_radius) ?
                 in_i.start_radius - in_i.stop_radius :
                 in_i.stop_radius - in_i.start_radius;
      r1_0_q  <= in_i.start_radius;
      r2_0_q  <= in_i.stop_radius;
      rsum0_q <= fsegm_pkg::RSUM_W'(in_i.start_radius) +
                 fsegm_pkg::RSUM_W'(in_i.stop_radius);
    end
  end

  // stage 1: all squares and radius products
  fsegm_pkg::op_e                 op1_q;
  logic                           miss1_q;
  logic [fsegm_pkg::SQ_W-1:0]     dx2_q, dy2_q, dz2_q;
  logic [fsegm_pkg::RSQ_W-1:0]    dr2_q, a11_q, a12_q, a22_q;
  logic [fsegm_pkg::RSUM_W-1:0]   rsum1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q   <= op0_q;
      miss1_q <= miss0_q;
      dx2_q   <= fsegm_pkg::SQ_W'(dx0_q) * fsegm_pkg::SQ_W'(dx0_q);
      dy2_q   <= fsegm_pkg::SQ_W'(dy0_q) * fsegm_pkg::SQ_W'(dy0_q);
      dz2_q   <= fsegm_pkg::SQ_W'(dz0_q) * fsegm_pkg::SQ_W'(dz0_q);
      // only the surface needs the slant term under the root
      dr2_q   <= (op0_q == fsegm_pkg::OP_SURFACE) ?
                 fsegm_pkg::RSQ_W'(dr0_q) * fsegm_pkg::RSQ_W'(dr0_q) : '0;
      a11_q   <= fsegm_pkg::RSQ_W'(r1_0_q) * fsegm_pkg::RSQ_W'(r1_0_q);
      a12_q   <= fsegm_pkg::RSQ_W'(r1_0_q) * fsegm_pkg::RSQ_W'(r2_0_q);
      a22_q   <= fsegm_pkg::RSQ_W'(r2_0_q) * fsegm_pkg::RSQ_W'(r2_0_q);
      rsum1_q <= rsum0_q;
    end
  end

  // stage 2: radicand and radius square sum
  fsegm_pkg::op_e                  op2_q;
  logic                            miss2_q;
  logic [fsegm_pkg::RAD_IN_W-1:0]  rad2_q;
  logic [fsegm_pkg::SUMSQ_W-1:0]   s2_q;
  logic [fsegm_pkg::RSUM_W-1:0]    rsum2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      op2_q   <= op1_q;
      miss2_q <= miss1_q;
      rad2_q  <= fsegm_pkg::RAD_IN_W'(dx2_q) + fsegm_pkg::RAD_IN_W'(dy2_q) +
                 fsegm_pkg::RAD_IN_W'(dz2_q) + fsegm_pkg::RAD_IN_W'(dr2_q);
      s2_q    <= fsegm_pkg::SUMSQ_W'(a11_q) + fsegm_pkg::SUMSQ_W'(a12_q) +
                 fsegm_pkg::SUMSQ_W'(a22_q);
      rsum2_q <= rsum1_q;
    end
  end

  // square root stages, four digits each; side data rides along
  fsegm_pkg::sqrt_t sq_q   [fsegm_pkg::SQRT_STAGES];
  fsegm_pkg::side_t side_q [fsegm_pkg::SQRT_STAGES];
  fsegm_pkg::sqrt_t sq_in  [fsegm_pkg::SQRT_STAGES];
  fsegm_pkg::sqrt_t sq_out [fsegm_pkg::SQRT_STAGES];
  fsegm_pkg::side_t side_in[fsegm_pkg::SQRT_STAGES];

  always_comb begin
    sq_in[0].rad  = fsegm_pkg::RAD_W'(rad2_q);
    sq_in[0].rem  = '0;
    sq_in[0].root = '0;
    side_in[0].op      = op2_q;
    side_in[0].missing = miss2_q;
    side_in[0].rsum    = rsum2_q;
    // the volume constant is folded in while the root runs
    side_in[0].sp      = fsegm_pkg::SP_W'(s2_q) * fsegm_pkg::SP_W'(fsegm_pkg::PI_THIRD_Q16);
    for (int k = 1; k < fsegm_pkg::SQRT_STAGES; k++) begin
      sq_in[k]   = sq_q[k-1];
      side_in[k] = side_q[k-1];
    end
    for (int k = 0; k < fsegm_pkg::SQRT_STAGES; k++) begin
      sq_out[k] = sq_in[k];
      for (int j = 0; j < fsegm_pkg::SQRT_PER_ST; j++) begin
        sq_out[k] = fsegm_pkg::sqrt_step(sq_out[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < fsegm_pkg::SQRT_STAGES; k++) begin
        sq_q[k]   <= sq_out[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  // root is L for length and volume, the slant height for surface
  logic [fsegm_pkg::ROOT_W-1:0] root;
  fsegm_pkg::side_t             side_r;
  assign root   = sq_q[fsegm_pkg::SQRT_STAGES-1].root;
  assign side_r = side_q[fsegm_pkg::SQRT_STAGES-1];

  // multiply stage 1: surface first product, volume partial products
  fsegm_pkg::side_t               side_m1_q;
  logic [fsegm_pkg::ROOT_W-1:0]   root_m1_q;
  logic [fsegm_pkg::P1_W-1:0]     p1_q;
  logic [fsegm_pkg::VLO_W-1:0]    vlo_q;
  logic [fsegm_pkg::VHI_W-1:0]    vhi_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_m1_q <= side_r;
      root_m1_q <= root;
      p1_q      <= fsegm_pkg::P1_W'(side_r.rsum) * fsegm_pkg::P1_W'(root);
      vlo_q     <= fsegm_pkg::VLO_W'(root) *
                   fsegm_pkg::VLO_W'(side_r.sp[fsegm_pkg::SP_LO_W-1:0]);
      vhi_q     <= fsegm_pkg::VHI_W'(root) *
                   fsegm_pkg::VHI_W'(side_r.sp[fsegm_pkg::SP_W-1:fsegm_pkg::SP_LO_W]);
    end
  end

  // multiply stage 2: surface times pi, volume partial products combined
  fsegm_pkg::side_t               side_m2_q;
  logic [fsegm_pkg::ROOT_W-1:0]   root_m2_q;
  logic [fsegm_pkg::P2_W-1:0]     p2_q;
  logic [fsegm_pkg::V_W-1:0]      vol_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_m2_q <= side_m1_q;
      root_m2_q <= root_m1_q;
      p2_q      <= fsegm_pkg::P2_W'(p1_q) * fsegm_pkg::P2_W'(fsegm_pkg::PI_Q16);
      vol_q     <= fsegm_pkg::V_W'(vlo_q) +
                   (fsegm_pkg::V_W'(vhi_q) << fsegm_pkg::SP_LO_W);
    end
  end

  // final stage: scale, select, saturate
  logic [fsegm_pkg::P2_W-1:0]     surf_sh;
  logic [fsegm_pkg::V_W-1:0]      vol_sh;
  logic [fsegm_pkg::METRIC_W-1:0] metric_d;
  logic                           sat_d;

  assign surf_sh = p2_q >> fsegm_pkg::SURF_SHIFT;
  assign vol_sh  = vol_q >> fsegm_pkg::VOL_SHIFT;

  always_comb begin
    metric_d = '0;
    sat_d    = 1'b0;
    case (side_m2_q.op)
      fsegm_pkg::OP_SURFACE: begin
        if (surf_sh > fsegm_pkg::P2_W'(fsegm_pkg::METRIC_MAX)) begin
          metric_d = fsegm_pkg::METRIC_MAX;
          sat_d    = 1'b1;
        end else begin
          metric_d = surf_sh[fsegm_pkg::METRIC_W-1:0];
        end
      end
      fsegm_pkg::OP_VOLUME: begin
        if (vol_sh > fsegm_pkg::V_W'(fsegm_pkg::METRIC_MAX)) begin
          metric_d = fsegm_pkg::METRIC_MAX;
          sat_d    = 1'b1;
        end else begin
          metric_d = vol_sh[fsegm_pkg::METRIC_W-1:0];
        end
      end
      fsegm_pkg::OP_LENGTH: metric_d = fsegm_pkg::METRIC_W'(root_m2_q);
      fsegm_pkg::OP_MEAN:   metric_d = fsegm_pkg::METRIC_W'(side_m2_q.rsum >> 1);
      default:              metric_d = '0;
    endcase
    // an absent node forces zero for every metric
    if (side_m2_q.missing) begin
      metric_d = '0;
      sat_d    = 1'b0;
    end
  end

  logic [fsegm_pkg::METRIC_W-1:0] metric_q;
  logic                           sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      metric_q <= '0;
      sat_q    <= 1'b0;
    end else if (en) begin
      metric_q <= metric_d;
      sat_q    <= sat_d;
    end
  end

  assign out_o.metric    = metric_q;
  assign out_o.saturated = sat_q;

  // checks
  `FSEGM_ASSERT_ALWAYS(a_rst_no_valid, clk_i, !rst_ni |-> !out_o.valid, "valid during reset")
  `FSEGM_ASSERT(a_sat_max, clk_i, rst_ni, out_o.saturated |-> out_o.metric == fsegm_pkg::METRIC_MAX, "saturated but metric not at maximum")
  `FSEGM_ASSERT(a_stall_holds, clk_i, rst_ni, !en |=> $stable(v_q), "pipe moved during stall")
  `FSEGM_ASSERT(a_ready_rule, clk_i, rst_ni, in_i.ready == (out_o.ready || !out_o.valid), "input ready does not follow output slot")

endmodule
